// ===== rtl/mbd_pkg.sv =====
// Shared constants for the motion burst detector: register map, reset values,
// operating mode codes and datapath widths.
// No dependencies.
package mbd_pkg;

    localparam int unsigned AXIS_W  = 16;
    localparam int unsigned DELTA_W = 17;
    localparam int unsigned MAG_W   = 17;
    localparam int unsigned SQ_W    = 32;
    localparam int unsigned ACC_W   = 34;
    localparam int unsigned REM_W   = 19;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MS_W    = 16;

    localparam logic [2:0] REG_BASE_X      = 3'd0;
    localparam logic [2:0] REG_BASE_Y      = 3'd1;
    localparam logic [2:0] REG_BASE_Z      = 3'd2;
    localparam logic [2:0] REG_OPEN_LEVEL  = 3'd3;
    localparam logic [2:0] REG_PEAK_LEVEL  = 3'd4;
    localparam logic [2:0] REG_WINDOW_MS   = 3'd5;
    localparam logic [2:0] REG_COOLDOWN_MS = 3'd6;

    localparam logic [MAG_W-1:0] OPEN_LEVEL_RST  = 17'd24576;
    localparam logic [MAG_W-1:0] PEAK_LEVEL_RST  = 17'd32768;
    localparam logic [MS_W-1:0]  WINDOW_MS_RST   = 16'd300;
    localparam logic [MS_W-1:0]  COOLDOWN_MS_RST = 16'd500;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_ACTIVE   = 2'd1;
    localparam logic [1:0] MODE_COOLDOWN = 2'd2;

    // Last iteration index of the two-bits-per-step square root.
    localparam logic [4:0] ROOT_LAST = 5'd16;
    localparam logic [4:0] SQ_LAST   = 5'd3;

endpackage

// ===== rtl/motion_burst_detector.sv =====
// Motion burst detector top level: APB register file, shared squaring
// multiplier, iterative square root and the idle/active/cooldown machine.
// Depends on mbd_pkg.
//
// Usage: one three-axis sample and a millisecond timestamp enter on the slave
// stream; each accepted transaction yields exactly one result transaction on
// the master stream carrying the magnitude, the detection flag and the peak.
// Per sample the sequencer forms the baseline deviations, squares the three
// axes on one shared 17x17 multiplier and sums them, runs the two-bits-per-step
// square root and then takes a decision step. A new sample is taken only once
// the result has been loaded and the sequencer is back in idle, so samples are
// never overlapped.
// When the receiver stalls, the finished result holds in the output register
// while the next sample is processed; that sample waits in its decision step
// until the earlier result is taken.
// Reset (synchronous, active low) returns the registers to their defaults,
// the mode to idle and the timestamps and peak to zero.
// Registers lie at byte addresses 4*index; pready is tied high.
module motion_burst_detector
    import mbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream. tdata: raw_x[15:0], raw_y[31:16], raw_z[47:32], now_ms[79:48].
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,
    // Master stream. tdata: magnitude[16:0], peak_value[33:17], zeros[39:34].
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,
    // tuser: detected[0].
    output logic        o_m_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_SQ,
        S_ROOT,
        S_DECIDE
    } t_state;

    // Configuration registers.
    logic signed [AXIS_W-1:0] r_base_x, r_base_y, r_base_z;
    logic [MAG_W-1:0]         r_open_level, r_peak_level;
    logic [MS_W-1:0]          r_window_ms, r_cooldown_ms;

    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x      <= '0;
            r_base_y      <= '0;
            r_base_z      <= '0;
            r_open_level  <= OPEN_LEVEL_RST;
            r_peak_level  <= PEAK_LEVEL_RST;
            r_window_ms   <= WINDOW_MS_RST;
            r_cooldown_ms <= COOLDOWN_MS_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BASE_X:      r_base_x      <= pwdata[AXIS_W-1:0];
                REG_BASE_Y:      r_base_y      <= pwdata[AXIS_W-1:0];
                REG_BASE_Z:      r_base_z      <= pwdata[AXIS_W-1:0];
                REG_OPEN_LEVEL:  r_open_level  <= pwdata[MAG_W-1:0];
                REG_PEAK_LEVEL:  r_peak_level  <= pwdata[MAG_W-1:0];
                REG_WINDOW_MS:   r_window_ms   <= pwdata[MS_W-1:0];
                REG_COOLDOWN_MS: r_cooldown_ms <= pwdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_BASE_X:      prdata = {{16{r_base_x[AXIS_W-1]}}, r_base_x};
            REG_BASE_Y:      prdata = {{16{r_base_y[AXIS_W-1]}}, r_base_y};
            REG_BASE_Z:      prdata = {{16{r_base_z[AXIS_W-1]}}, r_base_z};
            REG_OPEN_LEVEL:  prdata = {15'd0, r_open_level};
            REG_PEAK_LEVEL:  prdata = {15'd0, r_peak_level};
            REG_WINDOW_MS:   prdata = {16'd0, r_window_ms};
            REG_COOLDOWN_MS: prdata = {16'd0, r_cooldown_ms};
            default:         prdata = '0;
        endcase
    end

    // Sequencer and datapath registers.
    t_state r_state;
    logic [4:0] r_cnt;
    logic signed [AXIS_W-1:0]  r_raw_x, r_raw_y, r_raw_z;
    logic [TIME_W-1:0]         r_now;
    logic signed [DELTA_W-1:0] r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]           r_prod;
    logic [ACC_W-1:0]          r_acc;
    logic [REM_W-1:0]          r_rem;
    logic [MAG_W-1:0]          r_root;

    // Detector state.
    logic [1:0]        r_mode;
    logic [TIME_W-1:0] r_win_start, r_cool_start;
    logic [MAG_W-1:0]  r_peak;

    // Output register.
    logic             r_m_valid;
    logic [MAG_W-1:0] r_m_mag, r_m_peak;
    logic             r_m_det;

    // Shared multiplier operand select.
    logic signed [DELTA_W-1:0]   w_sq_in;
    logic signed [2*DELTA_W-1:0] w_sq_full;

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    w_sq_in = r_dx;
            2'd1:    w_sq_in = r_dy;
            default: w_sq_in = r_dz;
        endcase
    end
    assign w_sq_full = w_sq_in * w_sq_in;

    // One step of the digit-by-digit square root.
    logic [REM_W+1:0] w_cand, w_trial;
    logic             w_fit;
    assign w_cand  = {r_rem, r_acc[ACC_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_fit   = (w_cand >= w_trial);

    // Decision logic, evaluated on the finished magnitude.
    logic [MAG_W-1:0]  w_peak_upd;
    logic [TIME_W-1:0] w_win_el, w_cool_el;
    logic              w_expired, w_settled, w_cooled;
    logic              w_close, w_det;
    assign w_peak_upd = (r_root > r_peak) ? r_root : r_peak;
    assign w_win_el   = r_now - r_win_start;
    assign w_cool_el  = r_now - r_cool_start;
    assign w_expired  = (w_win_el >= {16'd0, r_window_ms});
    assign w_cooled   = (w_cool_el >= {16'd0, r_cooldown_ms});
    assign w_settled  = ({r_root, 2'b00} < ({2'b00, r_open_level} + {1'b0, r_open_level, 1'b0}));
    assign w_close    = w_expired || w_settled;
    assign w_det      = (r_mode == MODE_ACTIVE) && w_close && (w_peak_upd >= r_peak_level);

    logic w_out_free;
    logic w_m_load;
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_m_load   = (r_state == S_DECIDE) && w_out_free;

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_mode       <= MODE_IDLE;
            r_win_start  <= '0;
            r_cool_start <= '0;
            r_peak       <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (w_m_load) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_raw_x <= i_s_tdata[15:0];
                        r_raw_y <= i_s_tdata[31:16];
                        r_raw_z <= i_s_tdata[47:32];
                        r_now   <= i_s_tdata[79:48];
                        r_state <= S_DELTA;
                    end
                end
                S_DELTA: begin
                    r_dx    <= {r_raw_x[AXIS_W-1], r_raw_x} - {r_base_x[AXIS_W-1], r_base_x};
                    r_dy    <= {r_raw_y[AXIS_W-1], r_raw_y} - {r_base_y[AXIS_W-1], r_base_y};
                    r_dz    <= {r_raw_z[AXIS_W-1], r_raw_z} - {r_base_z[AXIS_W-1], r_base_z};
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    // The product lands in a register before it is summed.
                    if (r_cnt != SQ_LAST) begin
                        r_prod <= w_sq_full[SQ_W-1:0];
                    end
                    if (r_cnt != 5'd0) begin
                        r_acc <= r_acc + {2'b00, r_prod};
                    end
                    if (r_cnt == SQ_LAST) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_ROOT: begin
                    r_acc <= {r_acc[ACC_W-3:0], 2'b00};
                    if (w_fit) begin
                        r_rem  <= REM_W'(w_cand - w_trial);
                        r_root <= {r_root[MAG_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_cand[REM_W-1:0];
                        r_root <= {r_root[MAG_W-2:0], 1'b0};
                    end
                    if (r_cnt == ROOT_LAST) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_DECIDE: begin
                    if (w_out_free) begin
                        r_m_mag  <= r_root;
                        r_m_det  <= w_det;
                        r_m_peak <= w_det ? w_peak_upd : '0;
                        unique case (r_mode)
                            MODE_ACTIVE: begin
                                r_peak <= w_peak_upd;
                                if (w_close) begin
                                    r_mode       <= MODE_COOLDOWN;
                                    r_cool_start <= r_now;
                                end
                            end
                            MODE_COOLDOWN: begin
                                if (w_cooled) begin
                                    r_mode <= MODE_IDLE;
                                end
                            end
                            default: begin
                                // The unused mode code behaves as idle.
                                if (r_root > r_open_level) begin
                                    r_mode      <= MODE_ACTIVE;
                                    r_win_start <= r_now;
                                    r_peak      <= r_root;
                                end else begin
                                    r_mode <= MODE_IDLE;
                                end
                            end
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'd0, r_m_peak, r_m_mag};
    assign o_m_tuser  = r_m_det;

    // A new sample is never taken while one is still being worked on.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while the sequencer is busy");

    // A result only appears out of the decision step.
    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_DECIDE))
        else $error("result raised outside the decision step");

    // Without a detection the peak field reads zero.
    a_peak_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[33:17] == '0))
        else $error("peak value nonzero without a detection");

    // A detected peak covers the magnitude of the closing sample.
    a_peak_covers_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[33:17] >= o_m_tdata[16:0]))
        else $error("detected peak below the closing magnitude");

    // The root iteration count stays within the radicand width.
    a_root_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_cnt <= ROOT_LAST))
        else $error("square root iteration count overrun");

endmodule

// ===== dv/mbd_checker.sv =====
// Result checker for the motion burst detector: follows the register writes,
// predicts one report per accepted sample and compares the master stream.
// Depends on mbd_pkg.
module mbd_checker
    import mbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // tdata: raw_x[15:0], raw_y[31:16], raw_z[47:32], now_ms[79:48].
    input  logic [79:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // tdata: magnitude[16:0], peak_value[33:17], zeros[39:34].
    input  logic [39:0] i_m_tdata,
    // tuser: detected[0].
    input  logic        i_m_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_detections
);

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             detected;
        logic [MAG_W-1:0] peak;
    } t_shock_report;

    t_shock_report predicted_reports[$];
    t_shock_report got, want;

    logic signed [AXIS_W-1:0] base_x, base_y, base_z;
    logic [MAG_W-1:0]         open_level, peak_level;
    logic [MS_W-1:0]          window_ms, cooldown_ms;
    logic [1:0]               run_mode;
    logic [TIME_W-1:0]        window_start, cooldown_start;
    logic [MAG_W-1:0]         peak_so_far;

    int error_count = 0;
    int result_count = 0;
    int detect_count = 0;

    // Runs the detector machine over one sample and queues the report it owes.
    task automatic forecast_report(input logic [79:0] sample);
        logic signed [AXIS_W-1:0] rx, ry, rz;
        logic [TIME_W-1:0]        now;
        longint                   dx, dy, dz;
        logic [63:0]              rem, root, one_b;
        logic [MAG_W-1:0]         mag;
        t_shock_report            rpt;
        rx = sample[15:0];
        ry = sample[31:16];
        rz = sample[47:32];
        now = sample[79:48];
        dx = longint'(rx) - longint'(base_x);
        dy = longint'(ry) - longint'(base_y);
        dz = longint'(rz) - longint'(base_z);
        rem = 64'(dx * dx + dy * dy + dz * dz);
        root = '0;
        one_b = 64'd1 << 62;
        while (one_b > rem) one_b = one_b >> 2;
        while (one_b != 0) begin
            if (rem >= root + one_b) begin
                rem = rem - (root + one_b);
                root = (root >> 1) + one_b;
            end else begin
                root = root >> 1;
            end
            one_b = one_b >> 2;
        end
        mag = root[MAG_W-1:0];
        rpt.magnitude = mag;
        rpt.detected = 1'b0;
        rpt.peak = '0;
        case (run_mode)
            MODE_ACTIVE: begin
                if (mag > peak_so_far) peak_so_far = mag;
                // Close on expiry or once the magnitude drops under 3/4 of the opening level.
                if ((now - window_start) >= {16'd0, window_ms} ||
                    ({3'b000, mag} << 2) < (20'd3 * {3'b000, open_level})) begin
                    if (peak_so_far >= peak_level) begin
                        rpt.detected = 1'b1;
                        rpt.peak = peak_so_far;
                    end
                    run_mode = MODE_COOLDOWN;
                    cooldown_start = now;
                end
            end
            MODE_COOLDOWN: begin
                if ((now - cooldown_start) >= {16'd0, cooldown_ms}) run_mode = MODE_IDLE;
            end
            default: begin
                // The unused code falls back to idle as well.
                run_mode = MODE_IDLE;
                if (mag > open_level) begin
                    run_mode = MODE_ACTIVE;
                    window_start = now;
                    peak_so_far = mag;
                end
            end
        endcase
        predicted_reports.push_back(rpt);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_x = '0;
            base_y = '0;
            base_z = '0;
            open_level = OPEN_LEVEL_RST;
            peak_level = PEAK_LEVEL_RST;
            window_ms = WINDOW_MS_RST;
            cooldown_ms = COOLDOWN_MS_RST;
            run_mode = MODE_IDLE;
            window_start = '0;
            cooldown_start = '0;
            peak_so_far = '0;
            predicted_reports.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_BASE_X:      base_x = i_pwdata[AXIS_W-1:0];
                    REG_BASE_Y:      base_y = i_pwdata[AXIS_W-1:0];
                    REG_BASE_Z:      base_z = i_pwdata[AXIS_W-1:0];
                    REG_OPEN_LEVEL:  open_level = i_pwdata[MAG_W-1:0];
                    REG_PEAK_LEVEL:  peak_level = i_pwdata[MAG_W-1:0];
                    REG_WINDOW_MS:   window_ms = i_pwdata[MS_W-1:0];
                    REG_COOLDOWN_MS: cooldown_ms = i_pwdata[MS_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.magnitude = i_m_tdata[MAG_W-1:0];
                got.peak = i_m_tdata[2*MAG_W-1:MAG_W];
                got.detected = i_m_tuser;
                result_count++;
                if (got.detected) detect_count++;
                if (predicted_reports.size() == 0) begin
                    if (error_count < 10)
                        $display("unexpected result: mag=%0d det=%0d peak=%0d",
                                 got.magnitude, got.detected, got.peak);
                    error_count++;
                end else begin
                    want = predicted_reports.pop_front();
                    if (got.magnitude !== want.magnitude || got.detected !== want.detected ||
                        got.peak !== want.peak || i_m_tdata[39:34] !== 6'd0) begin
                        if (error_count < 10)
                            $display({"mismatch: expected mag=%0d det=%0d peak=%0d,",
                                      " got mag=%0d det=%0d peak=%0d"},
                                     want.magnitude, want.detected, want.peak,
                                     got.magnitude, got.detected, got.peak);
                        error_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) forecast_report(i_s_tdata);
        end
        o_pending <= predicted_reports.size();
        o_errors <= error_count;
        o_results <= result_count;
        o_detections <= detect_count;
    end

endmodule

// ===== dv/tb_motion_burst_detector.sv =====
// Testbench top for the motion burst detector: clock, reset, register setup,
// sample stimulus with bursty sender and stalling receiver, and the verdict.
// Depends on mbd_pkg, motion_burst_detector and mbd_checker.
module tb_motion_burst_detector;
    import mbd_pkg::*;

    localparam logic [2:0] REG_UNUSED  = 3'd7;
    localparam int         CYCLE_LIMIT = 600000;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [79:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending, results, detections;
    int cycle_count = 0;
    int accepted = 0;
    int settings = 0;
    int burst_left = 0;
    int sink_left = 0;
    bit sender_steady = 1'b0;
    bit sink_steady = 1'b0;
    int cfg_bx, cfg_by, cfg_bz, cfg_open;
    logic [31:0] clock_ms = '0;

    motion_burst_detector u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    mbd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_detections (detections)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: alternating ready and stall runs of random length, or always ready in steady mode.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_left <= 0;
        end else if (sink_steady) begin
            i_m_tready <= 1'b1;
        end else if (sink_left == 0) begin
            i_m_tready <= ~i_m_tready;
            sink_left <= i_m_tready ? $urandom_range(0, 12) : $urandom_range(0, 15);
        end else begin
            sink_left <= sink_left - 1;
        end
    end

    function automatic logic [15:0] axis_value(input int base, input int dev);
        int v;
        v = base + dev;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic int deviation(input int span);
        int d;
        d = (span <= 0) ? 0 : int'($urandom_range(0, span));
        return $urandom_range(0, 1) ? d : -d;
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Unused upper bits of each write carry junk, which the block must mask.
    task automatic configure(input int bx, input int by, input int bz, input int open_lv,
                             input int peak_lv, input int win, input int cool);
        apb_write(REG_BASE_X, ($urandom() & 32'hFFFF_0000) | (bx & 32'hFFFF));
        apb_write(REG_BASE_Y, ($urandom() & 32'hFFFF_0000) | (by & 32'hFFFF));
        apb_write(REG_BASE_Z, ($urandom() & 32'hFFFF_0000) | (bz & 32'hFFFF));
        apb_write(REG_OPEN_LEVEL, ($urandom() & 32'hFFFE_0000) | (open_lv & 32'h1FFFF));
        apb_write(REG_PEAK_LEVEL, ($urandom() & 32'hFFFE_0000) | (peak_lv & 32'h1FFFF));
        apb_write(REG_WINDOW_MS, ($urandom() & 32'hFFFF_0000) | (win & 32'hFFFF));
        apb_write(REG_COOLDOWN_MS, ($urandom() & 32'hFFFF_0000) | (cool & 32'hFFFF));
        apb_write(REG_UNUSED, $urandom());
        cfg_bx = bx;
        cfg_by = by;
        cfg_bz = bz;
        cfg_open = open_lv;
        settings++;
    endtask

    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z, input logic [31:0] t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_steady) gap = 0;
            else if ($urandom_range(0, 3) == 0) gap = $urandom_range(8, 40);
            else gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                i_s_tdata <= 80'({$urandom(), $urandom(), $urandom()});
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {t, z, y, x};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        accepted++;
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Quiet stretches and shock runs on a rising clock, plus raw noise.
    task automatic random_phase(input int quota, input int step_max, input int idle_mode);
        int sent, kind, run, i, lo, hi, lvl, q;
        sender_steady = idle_mode[0];
        sink_steady = idle_mode[1];
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(0, 99);
            run = (kind < 15) ? $urandom_range(1, 3) : $urandom_range(1, 8);
            for (i = 0; i < run; i++) begin
                if ($urandom_range(0, 49) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
                else clock_ms = clock_ms + $urandom_range(0, step_max);
                if (kind < 15) begin
                    send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()), $urandom());
                end else if (kind < 55) begin
                    q = cfg_open / 4;
                    send_sample(axis_value(cfg_bx, deviation(q)), axis_value(cfg_by, deviation(q)),
                                axis_value(cfg_bz, deviation(q)), clock_ms);
                end else begin
                    hi = cfg_open * 2 + 200;
                    if (hi > 65535) hi = 65535;
                    lo = cfg_open / 2;
                    if (lo > hi) lo = hi;
                    lvl = $urandom_range(lo, hi);
                    send_sample(axis_value(cfg_bx, deviation(lvl)), axis_value(cfg_by, deviation(lvl)),
                                axis_value(cfg_bz, $urandom_range(0, 1) ? lvl : -lvl), clock_ms);
                end
            end
            sent += run;
        end
        drain();
    endtask

    initial begin
        int rb;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples under the reset register values.
        send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd5);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'd10);
        send_sample(16'sd0, 16'sd0, 16'sd0, 32'd20);
        send_sample(16'sd30000, 16'sd0, 16'sd0, 32'd100);
        send_sample(16'sd0, 16'sd0, 16'sd0, 32'd520);
        // Exactly at the opening level does not open; one count above does.
        send_sample(16'sd24576, 16'sd0, 16'sd0, 32'd600);
        send_sample(16'sd24577, 16'sd0, 16'sd0, 32'd610);
        send_sample(16'sd18433, 16'sd0, 16'sd0, 32'd611);
        send_sample(16'sd0, -16'sd18432, 16'sd0, 32'd911);
        send_sample(16'sd100, -16'sd100, 16'sd7, 32'd1411);
        // A window that spans the timestamp wrap and then expires.
        send_sample(16'sd0, 16'sd0, -16'sd30000, 32'hFFFF_FF00);
        send_sample(16'sd20000, 16'sd20000, 16'sd20000, 32'h0000_0020);
        send_sample(16'sd20000, 16'sd20000, 16'sd20000, 32'h0000_002C);
        send_sample(-16'sd5, 16'sd3, -16'sd1, 32'h0000_002C + 32'd499);
        send_sample(16'sd0, 16'sd0, 16'sd0, 32'h0000_002C + 32'd500);
        send_sample(-16'sd32768, 16'sd32767, 16'sd0, 32'h0000_0300);
        send_sample(16'sd1, 16'sd2, 16'sd3, 32'h0000_0301);
        send_sample(-16'sd1, -16'sd1, -16'sd1, 32'h0000_0302);
        drain();

        configure(0, 0, 0, 2000, 3000, 40, 60);
        random_phase(200, 8, 0);
        // Zero-length window and cooldown with the baselines at their extremes.
        configure(-32768, 32767, -32768, 20000, 30000, 0, 0);
        random_phase(180, 6, 3);
        configure(123, -456, 789, 0, 0, 65535, 65535);
        random_phase(180, 3000, 0);
        configure(32767, -32768, 32767, 131071, 131071, 10, 10);
        random_phase(80, 5, 1);
        for (rb = 0; rb < 2; rb++) begin
            cfg_open = $urandom_range(1000, 30000);
            configure(deviation(2000), deviation(2000), deviation(2000), cfg_open,
                      $urandom_range(cfg_open, cfg_open * 3 / 2),
                      $urandom_range(0, 100), $urandom_range(0, 100));
            random_phase(130, 12, 2 * rb);
        end
        configure(0, 0, 0, 100, 0, 15, 5);
        random_phase(200, 4, 0);

        repeat (40) @(posedge i_clk);
        $display("Summary: %0d samples over %0d register settings, %0d reports checked, %0d detections.",
                 accepted, settings, results, detections);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
